@@ rtl/track_length_accumulator_macros.svh @@
// Assertion macros shared by the track length accumulator checker.
`ifndef TRACK_LENGTH_ACCUMULATOR_MACROS_SVH
`define TRACK_LENGTH_ACCUMULATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TLA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the next cycle.
`define TLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/tla_pkg.sv @@
// Shared types and constants of the track length accumulator.
package tla_pkg;
  localparam int ANG_W = 36;
  localparam int CW = 40;
  localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_Q30 = 40'sh0026DD3B6A;
  localparam logic signed [CW-1:0] ONE_Q30 = 40'sd1073741824;
  localparam logic [47:0] MAX48 = 48'hFFFFFFFFFFFF;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_SC_INIT = 4'd2;
  localparam logic [3:0] OP_ROT = 4'd3;
  localparam logic [3:0] OP_SC_STORE = 4'd4;
  localparam logic [3:0] OP_MUL = 4'd5;
  localparam logic [3:0] OP_SQRT_INIT = 4'd6;
  localparam logic [3:0] OP_SQRT = 4'd7;
  localparam logic [3:0] OP_VEC_INIT = 4'd8;
  localparam logic [3:0] OP_VEC = 4'd9;
  localparam logic [3:0] OP_DIST = 4'd10;
  localparam logic [3:0] OP_FINISH = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
    logic [5:0] step;
  } tla_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic start;
    logic finish;
  } tla_stat_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [5:0] i);
    logic signed [CW-1:0] r;
    case (i)
      6'd0: r = 40'sh3243F6A8;  6'd1: r = 40'sh1DAC6705;
      6'd2: r = 40'sh0FADBAFC;  6'd3: r = 40'sh07F56EA6;
      6'd4: r = 40'sh03FEAB76;  6'd5: r = 40'sh01FFD55B;
      6'd6: r = 40'sh00FFFAAA;  6'd7: r = 40'sh007FFF55;
      6'd8: r = 40'sh003FFFEA;  6'd9: r = 40'sh001FFFFD;
      6'd10: r = 40'sh000FFFFF; 6'd11: r = 40'sh0007FFFF;
      6'd12: r = 40'sh0003FFFF; 6'd13: r = 40'sh0001FFFF;
      6'd14: r = 40'sh0000FFFF; 6'd15: r = 40'sh00007FFF;
      6'd16: r = 40'sh00003FFF; 6'd17: r = 40'sh00001FFF;
      6'd18: r = 40'sh00000FFF; 6'd19: r = 40'sh000007FF;
      6'd20: r = 40'sh000003FF; 6'd21: r = 40'sh000001FF;
      6'd22: r = 40'sh000000FF; 6'd23: r = 40'sh0000007F;
      6'd24: r = 40'sh0000003F; 6'd25: r = 40'sh0000001F;
      6'd26: r = 40'sh0000000F; 6'd27: r = 40'sh00000008;
      6'd28: r = 40'sh00000004; 6'd29: r = 40'sh00000002;
      6'd30: r = 40'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

@@ rtl/tla_point_if.sv @@
// Handshake channel interfaces for track points and track results.
interface tla_point_if;
  logic valid;
  logic ready;
  logic signed [29:0] latitude;
  logic signed [30:0] longitude;
  logic track_start;
  logic track_end;
  modport source (output valid, latitude, longitude, track_start, track_end, input ready);
  modport sink (input valid, latitude, longitude, track_start, track_end, output ready);
endinterface

interface tla_result_if;
  logic valid;
  logic ready;
  logic [47:0] track_length;
  logic [7:0] track_number;
  logic [7:0] longest_track;
  logic [47:0] longest_length;
  modport source (output valid, track_length, track_number, longest_track, longest_length,
                  input ready);
  modport sink (input valid, track_length, track_number, longest_track, longest_length,
                output ready);
endinterface

@@ rtl/tla_datapath.sv @@
// Datapath: shared CORDIC unit, multiplier, square root and track registers.
module tla_datapath #(
  parameter int STEPS = 28,
  parameter int MAXT = 256
) (
  input  logic clk,
  input  logic rst,
  input  tla_pkg::tla_cmd_t cmd,
  output tla_pkg::tla_stat_t stat,
  input  logic signed [29:0] in_lat,
  input  logic signed [30:0] in_lon,
  input  logic in_start,
  input  logic in_end,
  input  logic [31:0] radius,
  output logic [47:0] o_len,
  output logic [7:0] o_num,
  output logic [7:0] o_best_idx,
  output logic [47:0] o_best_len
);
  import tla_pkg::*;

  logic signed [31:0] cur_lat, cur_lon, prev_lat, prev_lon;
  logic start_f, end_f, have_prev;
  logic [47:0] sum, best_len;
  logic [7:0] best_idx, tcount;
  logic signed [CW-1:0] x, y, z;
  logic flip;
  logic signed [CW-1:0] s1, c1, s2, c2, cd, prod_a, arg;
  logic [61:0] sq_v, sq_r, sq_b;
  logic neg;

  // Angle source for the three sin/cos passes.
  logic signed [ANG_W-1:0] ang, ang_r, ang_f;
  always_comb begin
    unique case (cmd.sel)
      2'd0: ang = ANG_W'(prev_lat) <<< 2;
      2'd1: ang = ANG_W'(cur_lat) <<< 2;
      default: ang = (ANG_W'(prev_lon) - ANG_W'(cur_lon)) <<< 2;
    endcase
    // Differences stay below 3*pi, so two corrections reduce fully.
    ang_r = ang;
    if (ang_r > PI_Q30) ang_r = ang_r - TWO_PI_Q30;
    if (ang_r > PI_Q30) ang_r = ang_r - TWO_PI_Q30;
    if (ang_r < -PI_Q30) ang_r = ang_r + TWO_PI_Q30;
    if (ang_r < -PI_Q30) ang_r = ang_r + TWO_PI_Q30;
    ang_f = ang_r;
    if (ang_r > HALF_PI_Q30) ang_f = PI_Q30 - ang_r;
    else if (ang_r < -HALF_PI_Q30) ang_f = -PI_Q30 - ang_r;
  end

  // Multiplier operands chosen by the step of the argument computation.
  // All operands are Q30 values below 2 in magnitude and fit 32 bits.
  // The square of the clamped argument shares the multiplier in SQRT_INIT.
  logic signed [31:0] ma, mb;
  logic signed [63:0] mfull;
  logic signed [CW-1:0] prod;
  always_comb begin
    if (cmd.op == OP_SQRT_INIT) begin
      ma = 32'(arg);
      mb = 32'(arg);
    end else begin
      case (cmd.step[1:0])
        2'd0: begin ma = 32'(s1); mb = 32'(s2); end
        2'd1: begin ma = 32'(c1); mb = 32'(c2); end
        default: begin ma = 32'(prod_a); mb = 32'(cd); end
      endcase
    end
    mfull = ma * mb;
    prod = CW'(mfull >>> 30);
  end

  logic signed [CW-1:0] arg_sum;
  assign arg_sum = arg + prod;
  // The folded angle is never negative and stays below 2^32.
  logic [63:0] dist_full;
  assign dist_full = radius * z[31:0];
  logic [48:0] sum_add;
  assign sum_add = {1'b0, sum} + 49'(dist_full[63:30]);
  logic [47:0] sum_new;
  assign sum_new = !have_prev ? sum : (sum_add[48] ? MAX48 : sum_add[47:0]);
  logic [61:0] sq_t;
  assign sq_t = sq_r + sq_b;
  logic [7:0] tc_next;
  assign tc_next = (tcount == 8'(MAXT - 1)) ? 8'd0 : tcount + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      sum <= '0;
      best_len <= '0;
      best_idx <= '0;
      tcount <= '0;
      prev_lat <= '0;
      prev_lon <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          cur_lat <= 32'(in_lat);
          cur_lon <= 32'(in_lon);
          start_f <= in_start;
          end_f <= in_end;
          if (in_start) begin
            sum <= '0;
            have_prev <= 1'b0;
          end
          arg <= '0;
        end
        OP_SC_INIT: begin
          x <= GAIN_Q30;
          y <= '0;
          z <= CW'(ang_f);
          flip <= (ang_r > HALF_PI_Q30) || (ang_r < -HALF_PI_Q30);
        end
        OP_ROT: begin
          if (z >= 0) begin
            x <= x - (y >>> cmd.step);
            y <= y + (x >>> cmd.step);
            z <= z - atan_q30(cmd.step);
          end else begin
            x <= x + (y >>> cmd.step);
            y <= y - (x >>> cmd.step);
            z <= z + atan_q30(cmd.step);
          end
        end
        OP_SC_STORE: begin
          unique case (cmd.sel)
            2'd0: begin s1 <= y; c1 <= flip ? -x : x; end
            2'd1: begin s2 <= y; c2 <= flip ? -x : x; end
            default: cd <= flip ? -x : x;
          endcase
        end
        OP_MUL: begin
          if (cmd.step[1:0] == 2'd1) prod_a <= prod;
          else arg <= arg_sum;
        end
        OP_SQRT_INIT: begin
          if (arg > ONE_Q30) arg <= ONE_Q30;
          else if (arg < -ONE_Q30) arg <= -ONE_Q30;
          neg <= arg < 0;
          if (cmd.step[0]) begin
            sq_v <= 62'(64'h1000_0000_0000_0000 - 64'(mfull));
            sq_r <= '0;
            sq_b <= 62'h1000_0000_0000_0000;
          end
        end
        OP_SQRT: begin
          if (sq_v >= sq_t) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
        end
        OP_VEC_INIT: begin
          x <= neg ? -arg : arg;
          y <= CW'(sq_r);
          z <= '0;
        end
        OP_VEC: begin
          if (y > 0) begin
            x <= x + (y >>> cmd.step);
            y <= y - (x >>> cmd.step);
            z <= z + atan_q30(cmd.step);
          end else begin
            x <= x - (y >>> cmd.step);
            y <= y + (x >>> cmd.step);
            z <= z - atan_q30(cmd.step);
          end
        end
        OP_DIST: begin
          // Step 0 mirrors a negative argument, step 1 drops a negative angle.
          if (!cmd.step[0]) begin
            if (neg) z <= CW'(PI_Q30) - z;
          end else if (z[CW-1]) begin
            z <= '0;
          end
        end
        OP_FINISH: begin
          prev_lat <= cur_lat;
          prev_lon <= cur_lon;
          have_prev <= ~end_f;
          if (end_f) begin
            o_len <= sum_new;
            o_num <= tcount;
            if (sum_new > best_len) begin
              best_len <= sum_new;
              best_idx <= tcount;
              o_best_idx <= tcount;
              o_best_len <= sum_new;
            end else begin
              o_best_idx <= best_idx;
              o_best_len <= best_len;
            end
            sum <= '0;
            tcount <= tc_next;
          end else begin
            sum <= sum_new;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.have_prev = have_prev;
  assign stat.start = start_f;
  assign stat.finish = end_f;
  logic unused;
  assign unused = ^{STEPS};
endmodule

@@ rtl/tla_controller.sv @@
// Controller: sequences the shared CORDIC and arithmetic steps for one point.
module tla_controller #(
  parameter int STEPS = 28
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  tla_pkg::tla_stat_t stat,
  output tla_pkg::tla_cmd_t cmd
);
  import tla_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_SCI = 4'd1, S_ROT = 4'd2, S_SCS = 4'd3,
                         S_MUL = 4'd4, S_SQI = 4'd5, S_SQ = 4'd6, S_VI = 4'd7,
                         S_VEC = 4'd8, S_DIST = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;

  logic [3:0] state;
  logic [5:0] step;
  logic [1:0] sel;
  logic has_out;

  assign in_ready = (state == S_IDLE) && !(has_out && !out_ready);
  assign out_valid = has_out;

  always_comb begin
    cmd.sel = sel;
    cmd.step = step;
    unique case (state)
      S_IDLE: cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
      S_SCI: cmd.op = OP_SC_INIT;
      S_ROT: cmd.op = OP_ROT;
      S_SCS: cmd.op = OP_SC_STORE;
      S_MUL: cmd.op = OP_MUL;
      S_SQI: cmd.op = OP_SQRT_INIT;
      S_SQ: cmd.op = OP_SQRT;
      S_VI: cmd.op = OP_VEC_INIT;
      S_VEC: cmd.op = OP_VEC;
      S_DIST: cmd.op = OP_DIST;
      S_FIN: cmd.op = OP_FINISH;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      sel <= '0;
      has_out <= 1'b0;
    end else begin
      if (has_out && out_ready) has_out <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          state <= S_SCI;
          sel <= 2'd0;
          step <= '0;
        end
        S_SCI: begin
          // Skip distance work for a track start or a point with no previous point.
          if (stat.start || !stat.have_prev) state <= S_FIN;
          else begin
            state <= S_ROT;
            step <= '0;
          end
        end
        S_ROT: begin
          if (step == 6'(STEPS - 1)) state <= S_SCS;
          step <= step + 1'b1;
        end
        S_SCS: begin
          step <= '0;
          if (sel == 2'd2) state <= S_MUL;
          else begin
            sel <= sel + 1'b1;
            state <= S_SCI;
          end
        end
        S_MUL: begin
          if (step == 6'd2) begin
            state <= S_SQI;
            step <= '0;
          end else step <= step + 1'b1;
        end
        S_SQI: begin
          // Step 0 clamps, step 1 squares the clamped argument.
          if (step[0]) begin
            state <= S_SQ;
            step <= '0;
          end else step <= 6'd1;
        end
        S_SQ: begin
          if (step == 6'd30) state <= S_VI;
          step <= step + 1'b1;
        end
        S_VI: begin
          state <= S_VEC;
          step <= '0;
        end
        S_VEC: begin
          if (step == 6'(STEPS - 1)) begin
            state <= S_DIST;
            step <= '0;
          end else step <= step + 1'b1;
        end
        S_DIST: begin
          if (step[0]) state <= S_FIN;
          else step <= 6'd1;
        end
        S_FIN: begin
          if (stat.finish) begin
            has_out <= 1'b1;
            state <= S_OUT;
          end else state <= S_IDLE;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/track_length_accumulator.sv @@
// Top level of the track length accumulator.
// Points are taken one at a time. A point with a previous point in its track
// holds the block until it can take the next point while it passes, all on one
// shared unit, through the accept state, three sin/cos passes of a setup, a
// CORDIC_STEPS rotation pass and a store each, the multiply steps, the clamp and
// square steps, the bit-serial square root, the vectoring setup, a CORDIC_STEPS
// vectoring pass, the angle fold and the finish step that adds the leg. A point
// with no previous point goes from the first sin/cos setup straight to the finish
// step. A track end adds an output state and loads the result register; the next
// point is not taken while an earlier result waits unaccepted.
module track_length_accumulator #(
  parameter int CORDIC_STEPS = 28,
  parameter int MAX_TRACKS = 256
) (
  input  logic clk,
  input  logic rst,
  tla_point_if.sink point,
  tla_result_if.source result,
  input  logic cfg_we,
  input  logic [31:0] cfg_wdata
);
  import tla_pkg::*;

  logic [31:0] radius;
  tla_cmd_t cmd;
  tla_stat_t stat;

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) radius <= 32'd417647524;
    else if (cfg_we) radius <= cfg_wdata;
  end

  tla_controller #(.STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid(point.valid), .in_ready(point.ready),
    .out_valid(result.valid), .out_ready(result.ready), .stat, .cmd
  );

  tla_datapath #(.STEPS(CORDIC_STEPS), .MAXT(MAX_TRACKS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_lat(point.latitude), .in_lon(point.longitude),
    .in_start(point.track_start), .in_end(point.track_end), .radius,
    .o_len(result.track_length), .o_num(result.track_number),
    .o_best_idx(result.longest_track), .o_best_len(result.longest_length)
  );
endmodule

@@ rtl/tla_checker.sv @@
// Port checker for the track length accumulator, bound to the top level.
`include "track_length_accumulator_macros.svh"
module tla_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [47:0] len,
  input logic [47:0] best
);
  `TLA_ASSERT_IMPL(a_best_ge, clk, rst, out_valid, best >= len)
  `TLA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TLA_ASSERT_IMPL(a_no_take_busy, clk, rst, out_valid && !out_ready, !in_ready)
  `TLA_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
endmodule

bind track_length_accumulator tla_checker u_chk (
  .clk, .rst, .in_valid(point.valid), .in_ready(point.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .len(result.track_length), .best(result.longest_length)
);

@@ sim/tb_track_length_accumulator.sv @@
// Self-checking testbench for the track length accumulator: directed table, random tracks.
`timescale 1ns / 1ps

module tb_track_length_accumulator;

  // Fixed-point constants of the distance arithmetic, angles in Q30.
  localparam longint PI_FX = 64'sd3373259426;
  localparam longint HALF_PI_FX = 64'sd1686629713;
  localparam longint TWO_PI_FX = 64'sd6746518852;
  localparam longint ROT_GAIN = 64'sh26DD3B6A;
  localparam longint UNIT_FX = 64'sd1073741824;
  localparam int ROT_STEPS = 28;
  localparam logic [31:0] RADIUS_DEFAULT = 32'd417647524;
  localparam logic [47:0] SUM_MAX = 48'hFFFFFFFFFFFF;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [29:0] LAT_HI = 30'sd421657428;
  localparam logic signed [30:0] LON_HI = 31'sd843314857;

  typedef struct {
    logic [47:0] track_length;
    logic [7:0] track_number;
    logic [7:0] longest_track;
    logic [47:0] longest_length;
  } track_summary_t;

  typedef struct {
    logic signed [29:0] latitude;
    logic signed [30:0] longitude;
    logic track_start;
    logic track_end;
    logic typed;
    track_summary_t summary;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  tla_point_if point_ch ();
  tla_result_if result_ch ();

  track_length_accumulator dut (
    .clk(clk),
    .rst(rst),
    .point(point_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Arctangent table of the rotation steps, Q30.
  longint arctan_steps [0:30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001};

  // Shadow copy of the block state and its radius register.
  logic [31:0] radius_reg = RADIUS_DEFAULT;
  longint last_lat = 0;
  longint last_lon = 0;
  logic have_last = 1'b0;
  logic [47:0] running_sum = '0;
  logic [47:0] record_length = '0;
  logic [7:0] record_index = '0;
  logic [7:0] finished_tracks = '0;

  track_summary_t pending_summaries [$];
  int mismatches = 0;
  int points_sent = 0;
  int summaries_checked = 0;
  int tracks_sent = 0;
  int cycle_count = 0;

  // Sine and cosine of a Q28 angle by rotation, results in Q30.
  task automatic rotate_sincos(input longint a28, output longint s, output longint c);
    longint z, x, y, dx, dy;
    logic flip;
    z = a28 * 4;
    x = ROT_GAIN;
    y = 0;
    flip = 1'b0;
    while (z > PI_FX) z -= TWO_PI_FX;
    while (z < -PI_FX) z += TWO_PI_FX;
    if (z > HALF_PI_FX) begin
      z = PI_FX - z;
      flip = 1'b1;
    end else if (z < -HALF_PI_FX) begin
      z = -PI_FX - z;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_steps[i];
      end else begin
        x += dx; y -= dy; z += arctan_steps[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  // Integer square root, bit by bit.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Arc cosine of a clamped Q30 value by vectoring, never negative.
  function automatic longint arc_cosine(input longint c);
    longint ac, x, y, z, dx, dy, r;
    logic neg;
    neg = c < 0;
    ac = neg ? -c : c;
    x = ac;
    y = longint'(root_floor((64'd1 << 60) - longint'(ac * ac)));
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_steps[i];
      end else begin
        x -= dx; y += dy; z -= arctan_steps[i];
      end
    end
    r = neg ? PI_FX - z : z;
    return (r < 0) ? 0 : r;
  endfunction

  // Great circle distance of one leg in 1/65536 km.
  task automatic leg_length(input longint lat1, input longint lon1, input longint lat2,
                            input longint lon2, output longint unsigned leg_len);
    longint s1, c1, s2, c2, sd, cd, arg;
    longint unsigned ang;
    rotate_sincos(lat1, s1, c1);
    rotate_sincos(lat2, s2, c2);
    rotate_sincos(lon1 - lon2, sd, cd);
    arg = ((s1 * s2) >>> 30) + ((((c1 * c2) >>> 30) * cd) >>> 30);
    if (arg > UNIT_FX) arg = UNIT_FX;
    if (arg < -UNIT_FX) arg = -UNIT_FX;
    ang = longint'(arc_cosine(arg));
    leg_len = ({32'd0, radius_reg} * ang) >> 30;
  endtask

  // Advances the shadow state by one point; returns 1 with a summary at a track end.
  task automatic track_point(input point_row_t p, output logic done,
                             output track_summary_t sm);
    longint unsigned d, total;
    done = 1'b0;
    sm = '{default: '0};
    if (p.track_start) begin
      running_sum = '0;
      have_last = 1'b0;
    end
    if (have_last) begin
      leg_length(last_lat, last_lon, longint'(p.latitude), longint'(p.longitude), d);
      total = {16'd0, running_sum} + d;
      running_sum = (total > {16'd0, SUM_MAX}) ? SUM_MAX : total[47:0];
    end
    last_lat = longint'(p.latitude);
    last_lon = longint'(p.longitude);
    have_last = 1'b1;
    if (p.track_end) begin
      if (running_sum > record_length) begin
        record_length = running_sum;
        record_index = finished_tracks;
      end
      sm.track_length = running_sum;
      sm.track_number = finished_tracks;
      sm.longest_track = record_index;
      sm.longest_length = record_length;
      running_sum = '0;
      have_last = 1'b0;
      finished_tracks = finished_tracks + 8'd1;
      done = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic int idle_draw();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  // Sends one point request and records the expected summary on acceptance.
  task automatic send_point(input point_row_t p);
    logic done;
    track_summary_t sm;
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_ch.valid <= 1'b1;
    point_ch.latitude <= p.latitude;
    point_ch.longitude <= p.longitude;
    point_ch.track_start <= p.track_start;
    point_ch.track_end <= p.track_end;
    do @(posedge clk); while (!point_ch.ready);
    points_sent++;
    track_point(p, done, sm);
    if (done) begin
      tracks_sent++;
      pending_summaries.push_back(p.typed ? p.summary : sm);
    end
  endtask

  // Waits out outstanding work, then writes the radius register.
  task automatic write_radius(input logic [31:0] value);
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_reg = value;
  endtask

  function automatic point_row_t make_point(input logic signed [29:0] la,
                                            input logic signed [30:0] lo,
                                            input logic s, input logic e);
    point_row_t p;
    p = '{default: '0};
    p.latitude = la;
    p.longitude = lo;
    p.track_start = s;
    p.track_end = e;
    return p;
  endfunction

  function automatic point_row_t make_typed(input logic signed [29:0] la,
                                            input logic signed [30:0] lo,
                                            input logic [47:0] len, input logic [7:0] num,
                                            input logic [7:0] best,
                                            input logic [47:0] best_len);
    point_row_t p;
    p = make_point(la, lo, 1'b1, 1'b1);
    p.typed = 1'b1;
    p.summary = '{len, num, best, best_len};
    return p;
  endfunction

  // One random track, well formed or broken, with random content.
  task automatic send_random_track();
    int n;
    point_row_t p;
    n = ($urandom_range(0, 9) < 8) ? 1 : $urandom_range(2, 5);
    for (int k = 0; k < n; k++) begin
      p = make_point(30'($urandom_range(0, 2 * LAT_HI) - LAT_HI),
                     31'($urandom_range(0, 2 * LON_HI) - LON_HI), k == 0, k == n - 1);
      if ($urandom_range(0, 9) == 0) begin
        // Noise: raw bit patterns and stray markers.
        p.latitude = 30'($urandom);
        p.longitude = 31'($urandom);
        p.track_start = 1'($urandom_range(0, 1));
        p.track_end = 1'($urandom_range(0, 1));
      end
      send_point(p);
    end
  endtask

  // Result side: random stalls, compare each summary with the oldest expectation.
  initial begin
    track_summary_t want;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      summaries_checked++;
      if (pending_summaries.size() == 0) begin
        report_mismatch("unexpected track_length", result_ch.track_length, 48'd0);
      end else begin
        want = pending_summaries.pop_front();
        if (result_ch.track_length !== want.track_length)
          report_mismatch("track_length", result_ch.track_length, want.track_length);
        if (result_ch.track_number !== want.track_number)
          report_mismatch("track_number", result_ch.track_number, want.track_number);
        if (result_ch.longest_track !== want.longest_track)
          report_mismatch("longest_track", result_ch.longest_track, want.longest_track);
        if (result_ch.longest_length !== want.longest_length)
          report_mismatch("longest_length", result_ch.longest_length, want.longest_length);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Point side: directed table, then random tracks over several radius settings.
  initial begin
    point_row_t rows [$];
    logic [31:0] radii [4];
    point_ch.valid = 1'b0;
    point_ch.latitude = '0;
    point_ch.longitude = '0;
    point_ch.track_start = 1'b0;
    point_ch.track_end = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-point tracks have zero length and never beat the record.
    rows.push_back(make_typed(0, 0, 0, 0, 0, 0));
    rows.push_back(make_typed(LAT_HI, LON_HI, 0, 1, 0, 0));
    rows.push_back(make_typed(-LAT_HI, -LON_HI, 0, 2, 0, 0));
    // Corners of the range.
    rows.push_back(make_point(-LAT_HI, -LON_HI, 1, 0));
    rows.push_back(make_point(LAT_HI, LON_HI, 0, 1));
    // Same point twice.
    rows.push_back(make_point(0, 0, 1, 0));
    rows.push_back(make_point(0, 0, 0, 1));
    // Start inside a track drops the partial sum.
    rows.push_back(make_point(30'sd1000000, 31'sd2000000, 1, 0));
    rows.push_back(make_point(30'sd5000000, -31'sd5000000, 0, 0));
    rows.push_back(make_point(-30'sd3000000, 31'sd7000000, 1, 0));
    rows.push_back(make_point(30'sd8000000, 31'sd9000000, 0, 1));
    // Points with no previous point and no start marker.
    rows.push_back(make_point(30'sd100000, 31'sd100000, 0, 0));
    rows.push_back(make_point(30'sd200000, -31'sd300000, 0, 1));
    // Two identical tracks: the earlier one keeps the record.
    rows.push_back(make_point(30'sd50000000, 31'sd60000000, 1, 0));
    rows.push_back(make_point(-30'sd70000000, 31'sd10000000, 0, 1));
    rows.push_back(make_point(30'sd50000000, 31'sd60000000, 1, 0));
    rows.push_back(make_point(-30'sd70000000, 31'sd10000000, 0, 1));
    // Antipodal points push the cosine argument to the clamp.
    rows.push_back(make_point(0, 0, 1, 0));
    rows.push_back(make_point(0, LON_HI, 0, 1));
    // Raw bit patterns beyond the valid angle range.
    rows.push_back(make_point(30'sh20000000, 31'sh40000000, 1, 0));
    rows.push_back(make_point(30'sh1FFFFFFF, 31'sh3FFFFFFF, 0, 1));
    foreach (rows[i]) send_point(rows[i]);

    // Random phase per radius setting, extremes included.
    radii = '{32'hFFFFFFFF, 32'd1, $urandom, RADIUS_DEFAULT};
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      while (points_sent < 21 + 110 * (ph + 1))
        send_random_track();
    end

    point_ch.valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d points in %0d tracks over four radius settings", points_sent,
             tracks_sent);
    $display("checked %0d track summaries, %0d mismatches", summaries_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
